/* sv/text_console_char_writer_defines.svh */
// Assertion macros for the text console character writer.
// Needs clk and rst in the scope of the module that uses them.
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define TCW_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define TCW_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tcw_pkg.sv */
// Shared types and codes for the text console character writer.
// No dependencies; used by tcw_rowmap and text_console_char_writer.
package tcw_pkg;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] EMPTY_CODE   = 8'd0;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } cmd_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic       scrolled;
  } res_t;

  // Row base pointer control.
  typedef struct packed {
    logic advance;  // scroll up one row
    logic home;     // back to physical row 0
  } map_ctl_t;

endpackage

/* sv/tcw_cell_ram.sv */
// Screen cell store: one write port, one read port, registered read data.
// No dependencies.
module tcw_cell_ram #(
  parameter int DEPTH = 3200,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Data holds between reads.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/tcw_rowmap.sv */
// Row base pointer: maps screen rows to physical rows of the cell store.
// Depends on tcw_pkg (map_ctl_t).
module tcw_rowmap #(
  parameter int ROWS = 25,
  parameter int RW   = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  tcw_pkg::map_ctl_t ctl,
  input  logic [RW-1:0]    lrow,
  output logic [RW-1:0]    prow
);

  localparam logic [RW:0]   ROWS_W = (RW+1)'(ROWS);
  localparam logic [RW-1:0] LAST   = RW'(ROWS - 1);

  logic [RW-1:0] base;
  logic [RW:0]   sum;

  always_ff @(posedge clk) begin
    if (rst || ctl.home) begin
      base <= '0;
    end else if (ctl.advance) begin
      base <= (base == LAST) ? '0 : RW'(base + 1'b1);
    end
  end

  // Both operands below ROWS, so one conditional subtract wraps.
  assign sum  = {1'b0, base} + {1'b0, lrow};
  assign prow = (sum >= ROWS_W) ? RW'(sum - ROWS_W) : RW'(sum);

endmodule

/* sv/text_console_char_writer.sv */
// Text console character writer: a COLUMNS x ROWS screen of 8-bit cells in
// one synchronous RAM, plus a cursor. One command word in gives one result
// word out. Scrolling moves a row base pointer, so only the new bottom row
// is blanked, by a sweep of writes along that row through the RAM port.
// A put writes its cell on the way to the result; a newline, ignored byte,
// unused op or read outside the screen goes straight to the result; a read
// inside the screen adds a RAM read state; a put or newline that scrolls
// adds a sweep of the bottom row; a clear sweeps the whole screen. After
// reset the block sweeps the whole screen and holds cmd_stall high
// meanwhile. Only one word is in work at a time; the result register lets
// the next command word in while a result still waits on res_stall.
// Depends on tcw_pkg, tcw_cell_ram, tcw_rowmap and the defines header.
`include "text_console_char_writer_defines.svh"

module text_console_char_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  tcw_pkg::cmd_t cmd_word,
  output logic          res_valid,
  input  logic          res_stall,
  output tcw_pkg::res_t res_word
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int CCW   = $clog2(COLUMNS + 1);
  localparam int AW    = RW + CW;
  localparam int DEPTH = ROWS * (2 ** CW);

  localparam logic [RW-1:0]  ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0]  COL_LAST = CW'(COLUMNS - 1);
  localparam logic [CCW-1:0] COL_PAST = CCW'(COLUMNS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SWEEP = 5'b00010,  // blanking rows through the RAM
    S_PUT   = 5'b00100,  // write char at cursor
    S_READ  = 5'b01000,  // RAM read in flight
    S_DONE  = 5'b10000   // result ready, waiting for output register
  } state_t;

  state_t             state;
  tcw_pkg::cmd_t      cmd_q;
  logic [CCW-1:0]     cur_col;
  logic [RW-1:0]      cur_row;
  logic [RW-1:0]      sw_row;
  logic [CW-1:0]      sw_col;
  logic               init_pass;   // sweep after reset, no result
  logic               scrolled_q;
  logic               rd_hit;      // read in range, take RAM data

  logic               accept;
  logic               last_row;
  logic               at_past;
  logic               is_put;
  logic               is_nl;
  logic               is_print;
  logic               scroll_now;
  logic               rd_in_range;
  logic               put_char_q;
  logic               out_free;
  tcw_pkg::map_ctl_t  map_ctl;
  tcw_pkg::res_t      res_next;

  logic [RW-1:0]      lrow;
  logic [RW-1:0]      prow;
  logic [CW-1:0]      col_sel;
  logic [AW-1:0]      ram_addr;
  logic               ram_we;
  logic [7:0]         ram_wdata;
  logic               ram_re;
  logic [7:0]         ram_rdata;

  // ---------------------------------------------------------------------
  // Command decode at the accepting edge
  // ---------------------------------------------------------------------
  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && (state == S_IDLE);
  assign last_row  = (cur_row == ROW_LAST);
  assign at_past   = (cur_col == COL_PAST);
  assign is_put    = (cmd_word.op == tcw_pkg::OP_PUT);
  assign is_nl     = (cmd_word.char_code == tcw_pkg::NEWLINE_CODE);
  assign is_print  = !is_nl && (cmd_word.char_code != tcw_pkg::EMPTY_CODE);

  // Newline on the bottom row, or a wrap off the bottom row: scroll first.
  assign scroll_now = accept && is_put && last_row && (is_nl || (is_print && at_past));

  assign rd_in_range = (32'(cmd_word.read_row) < ROWS) &&
                       (32'(cmd_word.read_col) < COLUMNS);

  assign put_char_q = (cmd_q.op == tcw_pkg::OP_PUT) &&
                      (cmd_q.char_code != tcw_pkg::NEWLINE_CODE) &&
                      (cmd_q.char_code != tcw_pkg::EMPTY_CODE);

  assign map_ctl.advance = scroll_now;
  assign map_ctl.home    = accept && (cmd_word.op == tcw_pkg::OP_CLEAR);

  assign out_free = !res_valid || !res_stall;

  // ---------------------------------------------------------------------
  // Cell store addressing: screen row -> physical row, column as low bits
  // ---------------------------------------------------------------------
  always_comb begin
    case (state)
      S_SWEEP: begin
        lrow    = sw_row;
        col_sel = sw_col;
      end
      S_READ: begin
        lrow    = RW'(cmd_q.read_row);
        col_sel = CW'(cmd_q.read_col);
      end
      default: begin
        lrow    = cur_row;
        col_sel = CW'(cur_col);
      end
    endcase
  end

  assign ram_addr  = {prow, col_sel};
  assign ram_we    = (state == S_SWEEP) || (state == S_PUT);
  assign ram_wdata = (state == S_PUT) ? cmd_q.char_code : tcw_pkg::EMPTY_CODE;
  assign ram_re    = (state == S_READ);

  tcw_rowmap #(
    .ROWS (ROWS),
    .RW   (RW)
  ) u_rowmap (
    .clk  (clk),
    .rst  (rst),
    .ctl  (map_ctl),
    .lrow (lrow),
    .prow (prow)
  );

  tcw_cell_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_cell_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_addr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_addr),
    .rd_data (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Result word; in S_PUT the cursor has not advanced yet
  // ---------------------------------------------------------------------
  always_comb begin
    res_next.cell_char  = rd_hit ? ram_rdata : tcw_pkg::EMPTY_CODE;
    res_next.cursor_col = (state == S_PUT) ? 7'(CCW'(cur_col + 1'b1)) : 7'(cur_col);
    res_next.cursor_row = 5'(cur_row);
    res_next.scrolled   = scrolled_q;
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE || state == S_PUT) && out_free) begin
      res_word <= res_next;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      init_pass  <= 1'b1;
      sw_row     <= '0;
      sw_col     <= '0;
      cur_col    <= '0;
      cur_row    <= '0;
      scrolled_q <= 1'b0;
      rd_hit     <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_q      <= cmd_word;
            scrolled_q <= scroll_now;
            rd_hit     <= 1'b0;
            state      <= S_DONE;
            case (cmd_word.op)
              tcw_pkg::OP_PUT: begin
                if (is_nl || (is_print && at_past)) begin
                  cur_col <= '0;
                  if (last_row) begin
                    // bottom row blanked after base moves
                    sw_row <= ROW_LAST;
                    sw_col <= '0;
                    state  <= S_SWEEP;
                  end else begin
                    cur_row <= RW'(cur_row + 1'b1);
                    if (is_print) begin
                      state <= S_PUT;
                    end
                  end
                end else if (is_print) begin
                  state <= S_PUT;
                end
              end
              tcw_pkg::OP_READ: begin
                if (rd_in_range) begin
                  rd_hit <= 1'b1;
                  state  <= S_READ;
                end
              end
              tcw_pkg::OP_CLEAR: begin
                cur_col <= '0;
                cur_row <= '0;
                sw_row  <= '0;
                sw_col  <= '0;
                state   <= S_SWEEP;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SWEEP: begin
          if (sw_col == COL_LAST) begin
            sw_col <= '0;
            if (sw_row == ROW_LAST) begin
              init_pass <= 1'b0;
              if (init_pass) begin
                state <= S_IDLE;
              end else if (put_char_q) begin
                state <= S_PUT;
              end else begin
                state <= S_DONE;
              end
            end else begin
              sw_row <= RW'(sw_row + 1'b1);
            end
          end else begin
            sw_col <= CW'(sw_col + 1'b1);
          end
        end
        S_PUT: begin
          cur_col <= CCW'(cur_col + 1'b1);
          if (out_free) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_DONE;
          end
        end
        S_READ: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `TCW_ASSERT_ALWAYS(a_row_range, 32'(cur_row) < ROWS, "cursor row past bottom")
  `TCW_ASSERT_ALWAYS(a_col_range, 32'(cur_col) <= COLUMNS, "cursor column overrun")
  `TCW_ASSERT_ALWAYS(a_put_in_bounds, (state != S_PUT) || (32'(cur_col) < COLUMNS), "put outside row")
  `TCW_ASSERT_NEXT(a_scroll_blanks_bottom, scroll_now, (state == S_SWEEP) && (sw_row == ROW_LAST), "scroll without bottom row sweep")

endmodule
